/* rtl/fwdf_pkg.sv */
// Shared constants and types for the fixed-width decimal formatter.
package fwdf_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned MAX_DIGITS_DEF = 9;

  // Magnitude bits of a non-negative value and the decimal digits they can need.
  localparam int unsigned BIN_W      = VALUE_W - 1;
  localparam int unsigned BCD_DIGITS = 10;

  // Double-dabble shift steps done per pipeline stage.
  localparam int unsigned DD_STEPS  = 8;
  localparam int unsigned DD_STAGES = (BIN_W + DD_STEPS - 1) / DD_STEPS;

  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_MORE = 7'h3E;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;   // bits still to shift in, msb first
    bcd_t             bcd;
    logic             neg;
    logic [CFG_W-1:0] width; // field width, already clamped, never zero
  } dd_item_t;

endpackage

/* rtl/fwdf_dd_stage.sv */
// One registered stage of the pipelined binary to BCD converter.
module fwdf_dd_stage
  import fwdf_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dd_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dd_item_t out_item_o
);

  localparam int unsigned BitsLeft = BIN_W - STAGE * DD_STEPS;
  localparam int unsigned Steps    = (BitsLeft < DD_STEPS) ? BitsLeft : DD_STEPS;

  logic     valid_q;
  dd_item_t item_q, item_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // add-3 correction on each digit, then shift one binary bit in
  always_comb begin
    item_d = in_item_i;
    for (int s = 0; s < Steps; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (item_d.bcd[d] >= 4'd5) begin
          item_d.bcd[d] = item_d.bcd[d] + 4'd3;
        end
      end
      item_d.bcd = bcd_t'({item_d.bcd[BCD_DIGITS-1:0]} << 1) | bcd_t'(item_d.bin[BIN_W-1]);
      item_d.bin = {item_d.bin[BIN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/fwdf_serializer.sv */
// Character serializer: holds one formatted field and sends it a beat at a time.
module fwdf_serializer
  import fwdf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [MAX_DIGITS-1:0][CHAR_W-1:0]   in_chars_i,
  input  logic [CFG_W-1:0]                    in_width_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [CHAR_W-1:0]                   out_char_o,
  output logic                                out_last_o
);

  logic [MAX_DIGITS-1:0][CHAR_W-1:0] chars_q;
  logic [CFG_W-1:0]                  remain_q;

  assign out_valid_o = (remain_q != '0);
  assign out_last_o  = (remain_q == CFG_W'(1));
  assign out_char_o  = chars_q[0];

  // take the next field when empty or while the final beat leaves
  assign in_ready_o = !out_valid_o || (out_last_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (in_ready_o) begin
      remain_q <= in_valid_i ? in_width_i : '0;
    end else if (out_ready_i) begin
      remain_q <= remain_q - CFG_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      if (in_valid_i) begin
        chars_q <= in_chars_i;
      end
    end else if (out_ready_i) begin
      chars_q <= (MAX_DIGITS * CHAR_W)'(chars_q >> CHAR_W);
    end
  end

endmodule

/* rtl/fixed_width_decimal_formatter.sv */
// Fixed-width decimal formatter: signed value in, ASCII field out a character per beat.
//
// Input stream (s_axis_*): one beat carries a 32-bit two's complement value.
// Output stream (m_axis_*): one beat per character, most significant first;
// tlast marks the final character of the field.
// cfg_we_i/cfg_wdata_i write the field width (0..15, saturates to MAX_DIGITS);
// write it only while the block is idle. A width of zero drops values silently.
// Negative values give a field of dashes; values of at least 10**width give
// '>' followed by the low width-1 digits; other values are zero padded.
// The first character of a field becomes valid once its input beat has passed
// four binary to BCD stages of up to eight shift steps each, a formatting
// register and the serializer register.
// The pipeline takes a beat every cycle while nothing ahead stalls; the output
// port sends width characters per value, fields following back to back.
// Reset clears the width to zero and empties the pipeline. A stalled output
// holds its beat; the stages behind it fill and then deassert s_axis_tready.
module fixed_width_decimal_formatter
  import fwdf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,   // digit_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,  // [31:0] value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [6:0] character, [7] zero
  output logic               m_axis_tlast   // is_last
);

  logic [CFG_W-1:0] digit_count_q;
  logic [CFG_W-1:0] width_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= '0;
    end else if (cfg_we_i) begin
      digit_count_q <= cfg_wdata_i;
    end
  end

  assign width_in = (digit_count_q > CFG_W'(MAX_DIGITS)) ? CFG_W'(MAX_DIGITS) : digit_count_q;

  // binary to BCD pipeline
  logic     dd_valid [DD_STAGES+1];
  logic     dd_ready [DD_STAGES+1];
  dd_item_t dd_item  [DD_STAGES+1];

  always_comb begin
    dd_item[0].bin   = s_axis_tdata[BIN_W-1:0];
    dd_item[0].bcd   = '0;
    dd_item[0].neg   = s_axis_tdata[VALUE_W-1];
    dd_item[0].width = width_in;
  end

  // a zero-width field is taken and dropped here
  assign dd_valid[0]   = s_axis_tvalid && (width_in != '0);
  assign s_axis_tready = dd_ready[0];

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    fwdf_dd_stage #(
      .STAGE(g)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (dd_valid[g]),
      .in_ready_o (dd_ready[g]),
      .in_item_i  (dd_item[g]),
      .out_valid_o(dd_valid[g+1]),
      .out_ready_i(dd_ready[g+1]),
      .out_item_o (dd_item[g+1])
    );
  end

  // formatting stage: digit order, padding, overflow and sign
  dd_item_t                          fin;
  logic                              fmt_valid_q;
  logic                              fmt_ready;
  logic [MAX_DIGITS-1:0][CHAR_W-1:0] fmt_chars_q, fmt_chars_d;
  logic [CFG_W-1:0]                  fmt_width_q;
  logic                              overflow;
  logic [CFG_W-1:0]                  sel;
  logic                              ser_ready;

  assign fin = dd_item[DD_STAGES];

  always_comb begin
    overflow = 1'b0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (CFG_W'(d) >= fin.width && fin.bcd[d] != 4'd0) begin
        overflow = 1'b1;
      end
    end
    for (int k = 0; k < MAX_DIGITS; k++) begin
      sel            = fin.width - CFG_W'(k) - CFG_W'(1);
      fmt_chars_d[k] = CH_ZERO;
      if (CFG_W'(k) < fin.width) begin
        fmt_chars_d[k] = CH_ZERO + CHAR_W'(fin.bcd[sel]);
      end
    end
    if (overflow) begin
      fmt_chars_d[0] = CH_MORE;
    end
    if (fin.neg) begin
      fmt_chars_d = {MAX_DIGITS{CH_DASH}};
    end
  end

  assign fmt_ready           = !fmt_valid_q || ser_ready;
  assign dd_ready[DD_STAGES] = fmt_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_valid_q <= 1'b0;
    end else if (fmt_ready) begin
      fmt_valid_q <= dd_valid[DD_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fmt_ready && dd_valid[DD_STAGES]) begin
      fmt_chars_q <= fmt_chars_d;
      fmt_width_q <= fin.width;
    end
  end

  logic [CHAR_W-1:0] out_char;

  fwdf_serializer #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fmt_valid_q),
    .in_ready_o (ser_ready),
    .in_chars_i (fmt_chars_q),
    .in_width_i (fmt_width_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
